// ===== rtl/seven_segment_scan_driver_core_macros.svh =====
// ----------------------------------------------------------------------------
// Seven-segment scan driver assertion macros
// Shorthand for clocked implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_CORE_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_CORE_MACROS_SVH

// same-cycle implication
`define SSD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg
// Constants, segment table and decimal split for the seven-segment driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int VALUE_W  = 14;
	localparam int PERIOD_W = 16;
	localparam int PHASE_W  = 3;
	localparam int SEG_W    = 8;

	localparam logic [VALUE_W-1:0]  VALUE_MAX    = 14'd9999;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

	typedef logic [SEG_W-1:0] seg_pattern_t;

	localparam seg_pattern_t SEG_PATTERN [10] = '{
		8'hEE, 8'h88, 8'hB6, 8'hBC, 8'hD8, 8'h7C, 8'h7E, 8'hA8, 8'hFE, 8'hFC
	};

	// decimal point is pattern bit 0
	localparam seg_pattern_t SEG_DP = 8'h01;

	typedef struct packed {
		logic [3:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] units;
	} digits_t;

	// saturate then split; reciprocal multiplies are exact for 0..9999
	function automatic digits_t split_digits(input logic [VALUE_W-1:0] raw);
		logic [VALUE_W-1:0] v;
		logic [29:0] p10;
		logic [26:0] p100;
		logic [27:0] p1000;
		logic [9:0]  q10;
		logic [6:0]  q100;
		logic [3:0]  q1000;
		digits_t     d;
		v      = (raw > VALUE_MAX) ? VALUE_MAX : raw;
		p10    = 30'(v) * 30'd52429;
		p100   = 27'(v) * 27'd5243;
		p1000  = 28'(v) * 28'd8389;
		q10    = 10'(p10 >> 19);
		q100   = 7'(p100 >> 19);
		q1000  = 4'(p1000 >> 23);
		d.thou  = q1000;
		d.hund  = 4'(q100 - 7'(q1000) * 7'd10);
		d.tens  = 4'(q10 - 10'(q100) * 10'd10);
		d.units = 4'(v - 14'(q10) * 14'd10);
		return d;
	endfunction

	function automatic seg_pattern_t seg_lookup(input logic [3:0] digit);
		seg_pattern_t p;
		if (digit <= 4'd9) begin
			p = SEG_PATTERN[digit];
		end else begin
			p = '0;
		end
		return p;
	endfunction

endpackage

// ===== rtl/seven_segment_scan_driver_core.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_core
// Scan driver for two four-digit seven-segment displays.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per scan tick. tdata = {right_value, left_value},
//   tuser = right_blink. Master stream: one item per tick, tdata =
//   {segment_select_n, digit_mask}.
//   cfg_we/cfg_wdata load blink_period; write only while the block is idle.
// Timing:
//   An item accepted on the slave side passes the input register, then the
//   result register, before it is presented on the master side.
//   One item per cycle sustained while m_axis_tready stays high; the digit
//   split and pattern lookup sit between the two registers.
// Reset:
//   arst_n clears both stages, the segment phase and the blink counter, and
//   sets blink_period to 1000. The first tick after reset drives segment 1.
// Stall:
//   While m_axis_tready is low the result holds; the input stage keeps one
//   more item, after which s_axis_tready drops. Nothing is dropped.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_core
	import ssd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,      // blink_period
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [13:0] left_value, [27:14] right_value, [31:28] zero
	input  logic        s_axis_tuser,   // [0] right_blink
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [7:0] digit_mask, [15:8] segment_select_n
);

	logic [PERIOD_W-1:0] period_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [PERIOD_W-1:0] blink_cnt_q;

	logic                valid_s1;
	logic [VALUE_W-1:0]  left_s1;
	logic [VALUE_W-1:0]  right_s1;
	logic                blank_s1;
	logic [PHASE_W-1:0]  phase_s1;

	logic                out_valid_q;
	logic [SEG_W-1:0]    mask_q;
	logic [SEG_W-1:0]    sel_n_q;

	logic                s_accept;
	logic                out_free;
	logic                adv_s1;
	logic [PHASE_W-1:0]  phase_next;
	logic [PERIOD_W:0]   cnt_inc;

	digits_t             ld;
	digits_t             rd;
	seg_pattern_t        lp [4];
	seg_pattern_t        rp [4];
	logic [SEG_W-1:0]    mask_c;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign phase_next    = phase_q + PHASE_W'(1);
	assign cnt_inc       = {1'b0, blink_cnt_q} + (PERIOD_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// scan state moves once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			blink_cnt_q <= '0;
		end else if (s_accept) begin
			phase_q <= phase_next;
			if (cnt_inc > {1'b0, period_q}) begin
				blink_cnt_q <= '0;
			end else begin
				blink_cnt_q <= cnt_inc[PERIOD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			left_s1  <= s_axis_tdata[13:0];
			right_s1 <= s_axis_tdata[27:14];
			blank_s1 <= s_axis_tuser && (blink_cnt_q < (period_q >> 1));
			phase_s1 <= phase_next;
		end
	end

	always_comb begin
		ld    = split_digits(left_s1);
		rd    = split_digits(right_s1);
		lp[0] = seg_lookup(ld.thou);
		lp[1] = seg_lookup(ld.hund);
		lp[2] = seg_lookup(ld.tens) | SEG_DP;
		lp[3] = seg_lookup(ld.units);
		rp[0] = seg_lookup(rd.thou);
		rp[1] = seg_lookup(rd.hund) | SEG_DP;
		rp[2] = seg_lookup(rd.tens);
		rp[3] = seg_lookup(rd.units);
		if (blank_s1) begin
			for (int i = 0; i < 4; i++) begin
				rp[i] = '0;
			end
		end
		// digit routing: left 5,6,7,4 / right 3,2,1,0
		mask_c = {lp[2][phase_s1], lp[1][phase_s1], lp[0][phase_s1], lp[3][phase_s1],
			rp[0][phase_s1], rp[1][phase_s1], rp[2][phase_s1], rp[3][phase_s1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			mask_q  <= mask_c;
			sel_n_q <= ~(SEG_W'(1) << phase_s1);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {sel_n_q, mask_q};

	`include "seven_segment_scan_driver_core_macros.svh"

	`SSD_ASSERT_NEXT(a_phase_step, s_accept, phase_q == $past(phase_next), "phase did not advance")
	`SSD_ASSERT_NEXT(a_s1_held, valid_s1 && !out_free, valid_s1, "input stage item lost")
	`SSD_ASSERT_SAME(a_sel_onehot, m_axis_tvalid, $onehot(~m_axis_tdata[15:8]), "select not one-hot")

endmodule

// ===== sim/seven_segment_scan_driver_core_test.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_core_test
// Self-checking bench for the two-display seven-segment scan driver.
// Scan ticks go in on the slave stream and every segment select and digit
// mask that comes out is compared against a cycle-free model of the segment
// phase, the blink counter and the decimal split. The run goes through a
// series of blink periods, the extremes among them, with random gaps and
// stalls on both streams.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_core_test;
	import ssd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 150;

	typedef struct packed {
		logic [7:0] select_n;
		logic [7:0] digit_mask;
	} scan_out_t;

	class scan_scoreboard;
		logic [2:0]  seg_phase;
		logic [15:0] blink_count;
		logic [15:0] period;
		scan_out_t   pending[$];
		int          errors;
		int          checked;

		function new();
			seg_phase   = '0;
			blink_count = '0;
			period      = PERIOD_RESET;
			errors      = 0;
			checked     = 0;
		endfunction

		function void set_period(logic [15:0] p);
			period = p;
		endfunction

		// pattern of one decimal digit, bit 0 is the decimal point
		function logic [7:0] digit_segments(int unsigned v, int unsigned div);
			logic [7:0] p;
			case ((v / div) % 10)
				0: p = 8'hEE;
				1: p = 8'h88;
				2: p = 8'hB6;
				3: p = 8'hBC;
				4: p = 8'hD8;
				5: p = 8'h7C;
				6: p = 8'h7E;
				7: p = 8'hA8;
				8: p = 8'hFE;
				default: p = 8'hFC;
			endcase
			return p;
		endfunction

		// one scan tick in, expected select and digit mask queued
		function void note_tick(logic [13:0] left, logic [13:0] right, logic blink);
			int unsigned lv, rv;
			logic [7:0]  lth, lhu, lte, lun, rth, rhu, rte, run;
			logic        blank;
			logic [16:0] next_count;
			scan_out_t   s;
			seg_phase = seg_phase + 3'd1;
			lv = (left > VALUE_MAX) ? VALUE_MAX : left;
			rv = (right > VALUE_MAX) ? VALUE_MAX : right;
			blank = blink && (blink_count < (period >> 1));
			lth = digit_segments(lv, 1000);
			lhu = digit_segments(lv, 100);
			lte = digit_segments(lv, 10) | 8'h01;
			lun = digit_segments(lv, 1);
			rth = digit_segments(rv, 1000);
			rhu = digit_segments(rv, 100) | 8'h01;
			rte = digit_segments(rv, 10);
			run = digit_segments(rv, 1);
			if (blank) begin
				{rth, rhu, rte, run} = '0;
			end
			s.digit_mask = {lte[seg_phase], lhu[seg_phase], lth[seg_phase], lun[seg_phase],
				rth[seg_phase], rhu[seg_phase], rte[seg_phase], run[seg_phase]};
			s.select_n = ~(8'd1 << seg_phase);
			pending.push_back(s);
			next_count = {1'b0, blink_count} + 17'd1;
			blink_count = (next_count > {1'b0, period}) ? 16'd0 : next_count[15:0];
		endfunction

		task report(string what, logic [7:0] want, logic [7:0] got);
			errors++;
			$display("mismatch in %s at result %0d: expected %02h, got %02h",
				what, checked, want, got);
		endtask

		task check_scan(logic [15:0] data);
			scan_out_t s;
			if (pending.size() == 0) begin
				report("unexpected result", 8'h00, data[7:0]);
			end else begin
				s = pending.pop_front();
				if (data[7:0] != s.digit_mask) begin
					report("digit_mask", s.digit_mask, data[7:0]);
				end
				if (data[15:8] != s.select_n) begin
					report("segment_select_n", s.select_n, data[15:8]);
				end
			end
			checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;

	scan_scoreboard scans = new();
	bit quiet;          // no gaps or stalls on either side
	int sink_hold;
	int idle_cycles;
	int ticks_sent;
	int periods_used;

	seven_segment_scan_driver_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				scans.check_scan(m_axis_tdata);
				sink_hold = quiet ? 0 : $urandom_range(0, 13);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				scans.note_tick(s_axis_tdata[13:0], s_axis_tdata[27:14], s_axis_tuser);
			end
			if (cfg_we) begin
				scans.set_period(cfg_wdata);
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("[seven_segment_scan_driver_core] ERROR");
					$finish;
				end
			end
		end
	end

	task send_tick(logic [13:0] left, logic [13:0] right, logic blink);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, right, left};
		s_axis_tuser  <= blink;
		do @(posedge clk); while (!s_axis_tready);
		ticks_sent++;
	endtask

	// stop sending and wait until every expected result is back
	task drain_scans();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (scans.pending.size() != 0) @(posedge clk);
	endtask

	task write_period(logic [15:0] p);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_we    <= 1'b0;
		periods_used++;
	endtask

	function logic [13:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 14'd0;
			1: return 14'd9999;
			2: return 14'h3FFF;
			3, 4: return 14'($urandom_range(10000, 16383));
			5: return 14'($urandom_range(0, 99));
			default: return 14'($urandom_range(0, 9999));
		endcase
	endfunction

	initial begin
		logic [15:0] period_plan [11];
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		quiet         = 1'b0;
		sink_hold     = 0;
		idle_cycles   = 0;
		ticks_sent    = 0;
		periods_used  = 0;
		period_plan   = '{16'd2, 16'd3, 16'd0, 16'd1, 16'd65535, 16'd200, 16'd9,
			16'd17, 16'($urandom_range(2, 300)), 16'd1000, 16'd64};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: every digit in every place, saturation, blanking at reset period
		for (int d = 0; d < 10; d++) begin
			send_tick(14'(d * 1111), 14'((9 - d) * 1111), d[0]);
		end
		send_tick(14'd0, 14'd0, 1'b0);
		send_tick(14'd9999, 14'd9999, 1'b1);
		send_tick(14'd10000, 14'd10000, 1'b0);
		send_tick(14'h3FFF, 14'h3FFF, 1'b1);
		send_tick(14'd1234, 14'd5678, 1'b0);
		send_tick(14'h2AAA, 14'h1555, 1'b1);
		send_tick(14'h1555, 14'h2AAA, 1'b0);
		send_tick(14'd9090, 14'd8080, 1'b1);
		drain_scans();

		foreach (period_plan[k]) begin
			quiet = (k % 4 == 3);
			write_period(period_plan[k]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_tick(pick_value(), pick_value(), 1'($urandom_range(0, 1)));
				if (k == 5 && n == PHASE_ITEMS / 2) begin
					drain_scans();
				end
			end
			drain_scans();
		end
		quiet = 1'b0;

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scans.pending.size() != 0) begin
			scans.report("leftover expectation", 8'h00, 8'h00);
		end
		$display("%0d scan ticks sent, %0d results checked, %0d blink period settings",
			ticks_sent, scans.checked, periods_used);
		$display("values span 0..16383 with saturation, periods span 0..65535");
		if (scans.errors == 0) begin
			$display("[seven_segment_scan_driver_core] OK");
		end else begin
			$display("[seven_segment_scan_driver_core] ERROR");
		end
		$finish;
	end

endmodule

// ===== seven_segment_scan_driver_core.f =====
+incdir+rtl
rtl/ssd_pkg.sv
rtl/seven_segment_scan_driver_core.sv
sim/seven_segment_scan_driver_core_test.sv
